// File: design/sine_wave_line_shift_defines.svh
// Assertion macros used by the checker of the line shifter.
`ifndef SINE_WAVE_LINE_SHIFT_DEFINES_SVH
`define SINE_WAVE_LINE_SHIFT_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define SWLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line shifter check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define SWLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line shifter check failed");

`endif

// File: design/swls_pkg.sv
package swls_pkg;

  // Sequencer states: one word goes IDLE, optional ADV, PIX, optional OFS1..OFS6, RESP.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV,
    S_PIX,
    S_OFS1,
    S_OFS2,
    S_OFS3,
    S_OFS4,
    S_OFS5,
    S_OFS6,
    S_RESP
  } swls_state_t;

  // Input word operations.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ACTIVE_WIDTH    = 2'd0,
    REG_ACTIVE_LINES    = 2'd1,
    REG_LINE_PHASE_STEP = 2'd2,
    REG_BLACK_LEVEL     = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [11:0] ACTIVE_WIDTH_RST    = 12'd720;
  localparam logic [11:0] ACTIVE_LINES_RST    = 12'd576;
  localparam logic [31:0] LINE_PHASE_STEP_RST = 32'd11867626;
  localparam logic [7:0]  BLACK_LEVEL_RST     = 8'h00;

  // Line counter wraps at no more than this many lines.
  localparam logic [11:0] MAX_LINES = 12'd2048;

  // Frame phase advance: turns per microsecond in units of 2^-48 turn.
  localparam logic [27:0] FRAME_RATE_K = 28'd223990670;

  // Polynomial sine coefficients, Q15 of a quarter turn in, Q1.15 out.
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;
  localparam logic [14:0] SIN_MAX = 15'h7FFF;

  // Reciprocal of ten in Q16, exact after truncation for operands below 16384.
  localparam logic [12:0] RECIP_TEN = 13'd6554;

  // Offset magnitude limit.
  localparam logic [6:0] OFFSET_MAX = 7'd127;

endpackage

// File: design/sine_wave_line_shift.sv
// Each input word passes through the sequencer: IDLE takes it, ADV runs on
// the first pixel of a frame, PIX uses the line store, the six-step offset
// chain OFS1..OFS6 runs on the pixel that completes a line, and RESP loads
// the output word. A new word is taken only after the last one leaves RESP.
// Reset (rst_n low, synchronous) restores register defaults, clears phases,
// counters and the held line; the line store itself is not cleared.
module sine_wave_line_shift
  import swls_pkg::*;
#(
  parameter int MAX_WIDTH        = 2048,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration port
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_sample,
  input  logic        in_first_of_frame,
  input  logic [31:0] in_elapsed_us,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_sample,
  output logic        out_out_valid,
  output logic        out_end_of_row
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int WW       = CW + 1;
  localparam int SW       = (CW + 2 > 9) ? CW + 2 : 9;
  localparam int RW       = WW + 12;
  localparam int SIN_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - SIN_BITS)) - 32'd1);
  localparam int MEM_DEPTH = 2 * MAX_WIDTH;

  // Sequencer
  swls_state_t state_r, state_nxt;

  // Configuration registers
  logic [11:0] active_width_r;
  logic [11:0] active_lines_r;
  logic [31:0] line_phase_step_r;
  logic [7:0]  black_level_r;

  // Frame and line state
  logic [31:0]       frame_phase_r;
  logic [31:0]       row_phase_r;
  logic [CW-1:0]     col_r;
  logic [10:0]       row_count_r;
  logic signed [7:0] held_offset_r;
  logic              held_valid_r;
  logic              bank_select_r;

  // Latched input word
  op_t         item_op_r;
  logic [7:0]  item_sample_r;
  logic [31:0] frame_delta_r;

  // Offset datapath
  logic [1:0]    quad_r;
  logic [15:0]   z_r;
  logic [15:0]   z2_r;
  logic [14:0]   t1_r;
  logic [15:0]   t2_r;
  logic [14:0]   m_r;
  logic [WW+14:0] wm_r;

  // Response and output registers
  logic [7:0] rd_data_r;
  logic       resp_hv_r;
  logic       resp_mem_r;
  logic       resp_end_r;
  logic       out_valid_r;
  logic [7:0] out_sample_r;
  logic       out_hv_r;
  logic       out_end_r;

  // Two banks of one line each.
  logic [7:0] line_mem [MEM_DEPTH];

  // Control strobes
  logic in_acc;
  logic adv_go;
  logic pix_go;
  logic ofs1_go, ofs2_go, ofs3_go, ofs4_go, ofs5_go, ofs6_go;
  logic load_out;

  // Combinational datapath
  logic [WW-1:0]  w_eff;
  logic [11:0]    lines_eff;
  logic [CW:0]    col_inc;
  logic           last;
  logic [SW-1:0]  src;
  logic           src_in_range;
  logic [11:0]    row_inc;
  logic [59:0]    frame_prod;
  logic [31:0]    sin_q;
  logic [14:0]    z_raw;
  logic [15:0]    z_fold;
  logic [31:0]    zz_prod;
  logic [27:0]    c_prod;
  logic [30:0]    a_prod;
  logic [31:0]    b_prod;
  logic [16:0]    m_full;
  logic [RW-1:0]  recip_prod;
  logic [RW-1:0]  off_full;
  logic [6:0]     off_mag;
  logic           mem_wr;
  logic           mem_rd;

  // Effective line width and line count, limited to their legal ranges.
  always_comb begin
    if (active_width_r == 12'd0) begin
      w_eff = WW'(1);
    end else if ((WW + 12)'(active_width_r) > (WW + 12)'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(active_width_r);
    end
    if (active_lines_r == 12'd0) begin
      lines_eff = 12'd1;
    end else if (active_lines_r > MAX_LINES) begin
      lines_eff = MAX_LINES;
    end else begin
      lines_eff = active_lines_r;
    end
  end

  // Column position, end of line and shifted source column.
  assign col_inc = {1'b0, col_r} + WW'(1);
  assign last    = (col_inc >= w_eff);
  assign src     = {{(SW - CW){1'b0}}, col_r} - {{(SW - 8){held_offset_r[7]}}, held_offset_r};
  assign src_in_range = !src[SW-1] && (src < {{(SW - WW){1'b0}}, w_eff});
  assign row_inc = {1'b0, row_count_r} + 12'd1;

  // Frame phase advance from the elapsed time.
  assign frame_prod = 60'(in_elapsed_us) * 60'(FRAME_RATE_K);

  // Quantized phase, quadrant fold and the polynomial products.
  assign sin_q   = (frame_phase_r + row_phase_r) & PHASE_MASK;
  assign z_raw   = sin_q[29:15];
  assign z_fold  = sin_q[30] ? (16'd32768 - {1'b0, z_raw}) : {1'b0, z_raw};
  assign zz_prod = 32'(z_r) * 32'(z_r);
  assign c_prod  = 28'(z2_r) * 28'(SIN_C);
  assign a_prod  = 31'(z2_r) * 31'(t1_r);
  assign b_prod  = 32'(z_r) * 32'(t2_r);
  assign m_full  = b_prod[31:15];

  // Offset magnitude: (w * m) / 655360 as (w * m >> 16) / 10, then limited.
  assign recip_prod = RW'(wm_r[WW+14:16]) * RW'(RECIP_TEN);
  assign off_full   = recip_prod >> 16;
  assign off_mag    = (off_full > RW'(OFFSET_MAX)) ? OFFSET_MAX : off_full[6:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (op_t'(in_op) == OP_PIXEL && in_first_of_frame) ? S_ADV : S_PIX;
        end
      end
      S_ADV:  state_nxt = S_PIX;
      S_PIX:  state_nxt = (item_op_r == OP_PIXEL && last) ? S_OFS1 : S_RESP;
      S_OFS1: state_nxt = S_OFS2;
      S_OFS2: state_nxt = S_OFS3;
      S_OFS3: state_nxt = S_OFS4;
      S_OFS4: state_nxt = S_OFS5;
      S_OFS5: state_nxt = S_OFS6;
      S_OFS6: state_nxt = S_RESP;
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    adv_go   = 1'b0;
    pix_go   = 1'b0;
    ofs1_go  = 1'b0;
    ofs2_go  = 1'b0;
    ofs3_go  = 1'b0;
    ofs4_go  = 1'b0;
    ofs5_go  = 1'b0;
    ofs6_go  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_ADV:  adv_go   = 1'b1;
      S_PIX:  pix_go   = 1'b1;
      S_OFS1: ofs1_go  = 1'b1;
      S_OFS2: ofs2_go  = 1'b1;
      S_OFS3: ofs3_go  = 1'b1;
      S_OFS4: ofs4_go  = 1'b1;
      S_OFS5: ofs5_go  = 1'b1;
      S_OFS6: ofs6_go  = 1'b1;
      S_RESP: load_out = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign in_acc = in_valid && in_ready;
  assign mem_wr = pix_go && (item_op_r == OP_PIXEL);
  assign mem_rd = pix_go && held_valid_r && src_in_range;

  // Control state, configuration and line bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      active_width_r    <= ACTIVE_WIDTH_RST;
      active_lines_r    <= ACTIVE_LINES_RST;
      line_phase_step_r <= LINE_PHASE_STEP_RST;
      black_level_r     <= BLACK_LEVEL_RST;
      frame_phase_r     <= '0;
      row_phase_r       <= '0;
      col_r             <= '0;
      row_count_r       <= '0;
      held_offset_r     <= '0;
      held_valid_r      <= 1'b0;
      bank_select_r     <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes.
      if (cfg_write_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_WIDTH:    active_width_r    <= cfg_data[11:0];
          REG_ACTIVE_LINES:    active_lines_r    <= cfg_data[11:0];
          REG_LINE_PHASE_STEP: line_phase_step_r <= cfg_data;
          REG_BLACK_LEVEL:     black_level_r     <= cfg_data[7:0];
          default: ;
        endcase
      end

      // Frame start: advance the phase and restart at the top line.
      if (adv_go) begin
        frame_phase_r <= frame_phase_r + frame_delta_r;
        row_phase_r   <= '0;
        row_count_r   <= '0;
        col_r         <= '0;
      end

      // Per-word column and line bookkeeping.
      if (pix_go) begin
        if (item_op_r == OP_PIXEL) begin
          if (last) begin
            bank_select_r <= ~bank_select_r;
            held_valid_r  <= 1'b1;
            col_r         <= '0;
            if (row_inc >= lines_eff) begin
              row_count_r <= '0;
              row_phase_r <= '0;
            end else begin
              row_count_r <= row_inc[10:0];
              row_phase_r <= row_phase_r + line_phase_step_r;
            end
          end else begin
            col_r <= col_inc[CW-1:0];
          end
        end else if (held_valid_r) begin
          if (last) begin
            held_valid_r <= 1'b0;
            col_r        <= '0;
          end else begin
            col_r <= col_inc[CW-1:0];
          end
        end
      end

      // New line offset, signed by the sine quadrant.
      if (ofs6_go) begin
        held_offset_r <= quad_r[1] ? -$signed({1'b0, off_mag}) : $signed({1'b0, off_mag});
      end

      // Output register handshake.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: input word, offset pipeline, response and output word.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_op_r     <= op_t'(in_op);
      item_sample_r <= in_sample;
      frame_delta_r <= frame_prod[47:16];
    end
    if (pix_go) begin
      quad_r     <= sin_q[31:30];
      z_r        <= z_fold;
      resp_hv_r  <= held_valid_r;
      resp_mem_r <= src_in_range;
      resp_end_r <= held_valid_r && last;
    end
    if (ofs1_go) begin
      z2_r <= zz_prod[30:15];
    end
    if (ofs2_go) begin
      t1_r <= SIN_B - 15'(c_prod[27:15]);
    end
    if (ofs3_go) begin
      t2_r <= SIN_A - a_prod[30:15];
    end
    if (ofs4_go) begin
      m_r <= (m_full > 17'(SIN_MAX)) ? SIN_MAX : m_full[14:0];
    end
    if (ofs5_go) begin
      wm_r <= (WW + 15)'(w_eff) * (WW + 15)'(m_r);
    end
    if (load_out) begin
      out_hv_r  <= resp_hv_r;
      out_end_r <= resp_end_r;
      if (!resp_hv_r) begin
        out_sample_r <= 8'h00;
      end else if (resp_mem_r) begin
        out_sample_r <= rd_data_r;
      end else begin
        out_sample_r <= black_level_r;
      end
    end
  end

  // Line store: write the current bank, read the held bank.
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      line_mem[{bank_select_r, col_r}] <= item_sample_r;
    end
    if (mem_rd) begin
      rd_data_r <= line_mem[{~bank_select_r, src[CW-1:0]}];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_sample = out_sample_r;
  assign out_out_valid  = out_hv_r;
  assign out_end_of_row = out_end_r;

endmodule

// File: design/swls_checker.sv
`include "sine_wave_line_shift_defines.svh"

module swls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_out_sample,
  input logic       out_out_valid,
  input logic       out_end_of_row
);

  // The block works on one word at a time.
  `SWLS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A stalled result word holds.
  `SWLS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_out_sample) && $stable(out_end_of_row))

  // With no held line the word is all zero.
  `SWLS_ASSERT_IMP(a_idle_word_zero, out_valid && !out_out_valid,
                   out_out_sample == 8'd0 && !out_end_of_row)

  // End of row only marks a replayed pixel.
  `SWLS_ASSERT_IMP(a_end_needs_held, out_valid && out_end_of_row, out_out_valid)

endmodule

bind sine_wave_line_shift swls_checker u_swls_checker (.*);

// File: tb/sv/line_shift_checker.sv
`timescale 1ns / 1ps

module line_shift_checker
  import swls_pkg::*;
#(
  parameter int MAX_WIDTH   = 2048,
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_sample,
  input  logic        in_first_of_frame,
  input  logic [31:0] in_elapsed_us,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_out_sample,
  input  logic        out_out_valid,
  input  logic        out_end_of_row,
  output int          fail_count,
  output int          pending,
  output int          drains_left
);

  // Offset = width * |sin| / (20 * 32768), truncated.
  localparam int unsigned OFFSET_DIV = 655360;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [7:0] pixel;
    logic       shown;
    logic       row_end;
  } shifted_px_t;

  // Local copies of the configuration registers.
  logic [11:0] width_reg;
  logic [11:0] lines_reg;
  logic [31:0] step_reg;
  logic [7:0]  black_reg;

  // Line shifter state: two line banks, phases, counters and the held line.
  logic [7:0]  line_mem [2][MAX_WIDTH];
  logic [31:0] frame_phase;
  logic [31:0] row_phase;
  int unsigned col_cnt;
  int unsigned row_cnt;
  int          held_shift;
  logic        line_held;
  logic        write_bank;

  shifted_px_t shifted_q[$];
  int          mismatches;

  assign fail_count = mismatches;

  // Effective line width, clamped to what the line store can hold.
  function automatic int unsigned row_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  // Effective number of lines before the row counter wraps.
  function automatic int unsigned line_count();
    if (lines_reg == 0) return 1;
    if (lines_reg > MAX_LINES) return MAX_LINES;
    return lines_reg;
  endfunction

  // Q1.15 sine of a phase in 2^-32 turn, quantized to the table resolution.
  function automatic int sine_q15(logic [31:0] phase);
    longint unsigned step_idx, q, z, z2, t, m;
    int unsigned quad;
    step_idx = phase;
    step_idx = (step_idx * TABLE_DEPTH) >> 32;
    q = (step_idx << 32) / TABLE_DEPTH;
    quad = int'(q >> 30);
    z = (q >> 15) & 64'h7FFF;
    // Odd quadrants run the quarter wave backwards.
    if ((quad & 1) != 0) z = 32768 - z;
    z2 = (z * z) >> 15;
    t = SIN_B - ((z2 * SIN_C) >> 15);
    t = SIN_A - ((z2 * t) >> 15);
    m = (z * t) >> 15;
    if (m > SIN_MAX) m = SIN_MAX;
    return (quad >= 2) ? -int'(m) : int'(m);
  endfunction

  // Signed horizontal shift of a line, saturated in magnitude.
  function automatic int row_shift(logic [31:0] phase, int unsigned w);
    int s;
    int unsigned mag, amount;
    s = sine_q15(phase);
    mag = (s < 0) ? -s : s;
    amount = (w * mag) / OFFSET_DIV;
    if (amount > OFFSET_MAX) amount = OFFSET_MAX;
    return (s < 0) ? -int'(amount) : int'(amount);
  endfunction

  // Applies one accepted input word and returns the word it produces.
  function automatic shifted_px_t predict_shifted_pixel(op_t op, logic [7:0] sample,
                                                        logic first, logic [31:0] elapsed);
    shifted_px_t px;
    logic [63:0] advance;
    int unsigned w, col;
    int src;
    logic last;
    px = '0;
    w = row_width();

    // A frame start advances the frame phase and drops any partial line.
    if (op == OP_PIXEL && first) begin
      advance = 64'(elapsed) * 64'(FRAME_RATE_K);
      frame_phase = frame_phase + advance[47:16];
      row_cnt = 0;
      row_phase = '0;
      col_cnt = 0;
    end

    col = col_cnt & (MAX_WIDTH - 1);
    last = (col + 1 >= w);

    // Replay the held line, shifted, with black where the source is outside it.
    if (line_held) begin
      src = int'(col) - held_shift;
      if (src >= 0 && src < int'(w)) px.pixel = line_mem[!write_bank][src];
      else px.pixel = black_reg;
      px.shown = 1'b1;
      px.row_end = last;
    end

    if (op == OP_PIXEL) begin
      line_mem[write_bank][col] = sample;
      if (last) begin
        held_shift = row_shift(frame_phase + row_phase, w);
        write_bank = !write_bank;
        line_held = 1'b1;
        col_cnt = 0;
        row_phase = row_phase + step_reg;
        row_cnt++;
        if (row_cnt >= line_count()) begin
          row_cnt = 0;
          row_phase = '0;
        end
      end else begin
        col_cnt = col + 1;
      end
    end else if (line_held) begin
      // A drain walks the held line out; the last one releases it.
      if (last) begin
        line_held = 1'b0;
        col_cnt = 0;
      end else begin
        col_cnt = col + 1;
      end
    end
    return px;
  endfunction

  // Number of drain words that empty the held line from the current column.
  function automatic int words_to_empty();
    int unsigned col;
    if (!line_held) return 0;
    col = col_cnt & (MAX_WIDTH - 1);
    return (col + 1 >= row_width()) ? 1 : int'(row_width() - col);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Track configuration, predict on every accepted input word, check every result word.
  always @(posedge clk) begin
    shifted_px_t want;
    if (!rst_n) begin
      width_reg   = ACTIVE_WIDTH_RST;
      lines_reg   = ACTIVE_LINES_RST;
      step_reg    = LINE_PHASE_STEP_RST;
      black_reg   = BLACK_LEVEL_RST;
      frame_phase = '0;
      row_phase   = '0;
      col_cnt     = 0;
      row_cnt     = 0;
      held_shift  = 0;
      line_held   = 1'b0;
      write_bank  = 1'b0;
      mismatches  = 0;
      shifted_q.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_ACTIVE_WIDTH:    width_reg = cfg_data[11:0];
          REG_ACTIVE_LINES:    lines_reg = cfg_data[11:0];
          REG_LINE_PHASE_STEP: step_reg  = cfg_data;
          REG_BLACK_LEVEL:     black_reg = cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (shifted_q.size() == 0) begin
          report_mismatch("unexpected word", out_out_sample, '0);
        end else begin
          want = shifted_q.pop_front();
          if (out_out_sample !== want.pixel)
            report_mismatch("out_sample", out_out_sample, want.pixel);
          if (out_out_valid !== want.shown)
            report_mismatch("out_valid field", out_out_valid, want.shown);
          if (out_end_of_row !== want.row_end)
            report_mismatch("end_of_row", out_end_of_row, want.row_end);
        end
      end

      if (in_valid && in_ready)
        shifted_q.push_back(predict_shifted_pixel(op_t'(in_op), in_sample,
                                                  in_first_of_frame, in_elapsed_us));
    end
    pending     <= shifted_q.size();
    drains_left <= words_to_empty();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import swls_pkg::*;

  localparam int MAX_WIDTH     = 2048;
  localparam int TABLE_DEPTH   = 256;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_PCT      = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_write_en = 1'b0;
  cfg_reg_t    cfg_index = REG_ACTIVE_WIDTH;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  op_t         in_op = OP_PIXEL;
  logic [7:0]  in_sample = '0;
  logic        in_first_of_frame = 1'b0;
  logic [31:0] in_elapsed_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_out_sample;
  logic        out_out_valid;
  logic        out_end_of_row;
  int          fail_count;
  int          pending;
  int          drains_left;

  // Sender bookkeeping: idling rate, words sent so far and position in the frame.
  int src_idle_pct = IDLE_PCT;
  int words_sent = 0;
  int row_len = 720;
  int frame_len = 720 * 576;
  int frame_pos = 0;

  sine_wave_line_shift #(
    .MAX_WIDTH(MAX_WIDTH),
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) dut (.*);

  line_shift_checker #(
    .MAX_WIDTH(MAX_WIDTH),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_inst (.*);

  initial forever #5 clk = ~clk;

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Writes all four registers and restarts the frame position.
  task automatic set_mode(int unsigned width, int unsigned lines, logic [31:0] step,
                          logic [7:0] black);
    write_reg(REG_ACTIVE_WIDTH, width);
    write_reg(REG_ACTIVE_LINES, lines);
    write_reg(REG_LINE_PHASE_STEP, step);
    write_reg(REG_BLACK_LEVEL, black);
    cfg_write_en <= 1'b0;
    row_len = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
    frame_len = row_len * ((lines == 0) ? 1 : ((lines > MAX_LINES) ? MAX_LINES : lines));
    frame_pos = 0;
  endtask

  // Offers one word, after a random gap, and returns at the edge that takes it.
  task automatic send_word(op_t op, logic [7:0] sample, logic first, logic [31:0] elapsed);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_sample <= sample;
    in_first_of_frame <= first;
    in_elapsed_us <= elapsed;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  // Brings the block to rest with no line held, so the width may change safely.
  task automatic settle();
    int n;
    in_valid <= 1'b0;
    wait_drained();
    n = drains_left;
    repeat (n) send_word(OP_DRAIN, $urandom, $urandom, $urandom);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames of random pixels, with stray drains and frame restarts.
  task automatic run_phase(int unsigned width, int unsigned lines, logic [31:0] step,
                           logic [7:0] black, int words);
    int pick;
    logic first;
    logic [31:0] elapsed;
    settle();
    set_mode(width, lines, step, black);
    repeat (words) begin
      pick = $urandom_range(99);
      src_idle_pct = (words_sent >= 700 && words_sent < 1000) ? 0 : IDLE_PCT;
      words_sent++;
      if (pick < 4) begin
        send_word(OP_DRAIN, $urandom, $urandom, $urandom);
      end else begin
        first = (frame_pos == 0) || (pick < 6);
        if (first) frame_pos = 0;
        elapsed = (pick < 50) ? $urandom : $urandom_range(100000);
        send_word(OP_PIXEL, $urandom, first, elapsed);
        frame_pos = (frame_pos + 1) % frame_len;
      end
    end
  endtask

  // Result side: random back-pressure, one long hold-off, and a stretch with none.
  initial begin : result_sink
    int taken;
    int hold;
    bit held_once;
    taken = 0;
    hold = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (taken == 400 && !held_once) begin
        held_once = 1'b1;
        hold = 200;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (taken >= 800 && taken < 1100) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run when no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: nothing is held yet, so every result word is blank.
    send_word(OP_DRAIN, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_PIXEL, 8'h00, 1'b1, 32'h0000_0000);
    send_word(OP_PIXEL, 8'hFF, 1'b0, 32'hFFFF_FFFF);
    settle();

    // Three-pixel lines, two per frame: line hold, drain mid-line, restart, row wrap.
    set_mode(3, 2, 32'hFFFF_FFFF, 8'h80);
    send_word(OP_PIXEL, 8'h01, 1'b1, 32'hFFFF_FFFF);
    send_word(OP_PIXEL, 8'h02, 1'b0, 32'h0);
    send_word(OP_PIXEL, 8'h03, 1'b0, 32'h0);
    send_word(OP_DRAIN, 8'h55, 1'b1, 32'h1234);
    send_word(OP_PIXEL, 8'hFE, 1'b0, 32'h0);
    send_word(OP_PIXEL, 8'h10, 1'b1, 32'd5000000);
    send_word(OP_PIXEL, 8'h20, 1'b0, 32'h0);
    send_word(OP_PIXEL, 8'h30, 1'b0, 32'h0);
    send_word(OP_PIXEL, 8'h40, 1'b0, 32'h0);
    send_word(OP_PIXEL, 8'h50, 1'b0, 32'h0);
    send_word(OP_PIXEL, 8'h60, 1'b0, 32'h0);
    settle();
    send_word(OP_DRAIN, 8'hAA, 1'b0, 32'h0);

    // Zero width and zero lines clamp to one: every pixel ends a line and a frame.
    settle();
    set_mode(0, 0, 32'h0, 8'hFF);
    send_word(OP_PIXEL, 8'h7F, 1'b1, 32'd200000);
    send_word(OP_PIXEL, 8'h80, 1'b0, 32'h0);
    send_word(OP_PIXEL, 8'hC3, 1'b0, 32'h0);
    send_word(OP_DRAIN, 8'h00, 1'b0, 32'h0);

    // Random phases over a spread of sizes, steps and fill levels.
    run_phase(64, 3, $urandom, 8'h00, 200);
    run_phase(21, 1, 32'h4000_0000, 8'h80, 150);
    run_phase(160, 4095, $urandom, $urandom, 250);
    run_phase(1, 5, $urandom, $urandom, 60);
    run_phase(100, 2048, 32'hFFFF_FFFF, 8'hFF, 200);
    run_phase(37, 7, $urandom, $urandom, 200);
    run_phase(4095, 2, $urandom, $urandom, 2100);
    run_phase(128, 2, $urandom, 8'h00, 250);
    run_phase(8, 3, $urandom, $urandom, 150);
    run_phase(200, 1, $urandom, 8'h80, 200);

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
